@@ rtl/artnet_packet_classifier_top_macros.svh @@
// Assertion macros shared by the Art-Net packet classifier RTL.
`ifndef ARTNET_PACKET_CLASSIFIER_TOP_MACROS_SVH
`define ARTNET_PACKET_CLASSIFIER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define APC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/apc_pkg.sv @@
// Package with constants, types and helpers for the Art-Net packet classifier.
package apc_pkg;

    // Default limits of the parser.
    localparam int MAX_CHANNELS_DEF = 512;
    localparam int BUFFER_BYTES_DEF = 530;

    // Width of the byte offset counter.
    localparam int OFF_W = 10;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // Header layout, as byte offsets into the UDP payload.
    localparam logic [OFF_W-1:0] OFF_IDENT_END = 10'd8;
    localparam logic [OFF_W-1:0] OFF_OPC_LO    = 10'd8;
    localparam logic [OFF_W-1:0] OFF_OPC_HI    = 10'd9;
    localparam logic [OFF_W-1:0] OFF_VER_HI    = 10'd10;
    localparam logic [OFF_W-1:0] OFF_VER_LO    = 10'd11;
    localparam logic [OFF_W-1:0] OFF_UNI_LO    = 10'd14;
    localparam logic [OFF_W-1:0] OFF_UNI_HI    = 10'd15;
    localparam logic [OFF_W-1:0] OFF_LEN_HI    = 10'd16;
    localparam logic [OFF_W-1:0] OFF_LEN_LO    = 10'd17;
    localparam logic [OFF_W-1:0] HDR_BYTES     = 10'd12;
    localparam logic [OFF_W-1:0] DMX_HDR_BYTES = 10'd18;

    // Opcodes and protocol limits.
    localparam logic [15:0] OP_POLL     = 16'h2000;
    localparam logic [15:0] OP_DMX      = 16'h5000;
    localparam logic [15:0] MIN_VERSION = 16'd14;

    // Packet verdict given on the final byte.
    typedef enum logic [2:0] {
        VERDICT_NONE      = 3'd0,
        VERDICT_ACCEPT    = 3'd1,
        VERDICT_MALFORMED = 3'd2,
        VERDICT_POLL      = 3'd3,
        VERDICT_IGNORED   = 3'd4
    } verdict_t;

    // One result transaction.
    typedef struct packed {
        logic [15:0] universe;
        verdict_t    verdict;
        logic [7:0]  level;
        logic [8:0]  channel;
        logic        data_valid;
    } result_t;

    // Expected identifier bytes: "Art-Net" followed by a zero byte.
    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/artnet_packet_classifier_top.sv @@
// Art-Net packet classifier: parses ArtDMX and ArtPoll payloads byte by byte.
//
//  Channel  Dir  Payload                                            Transaction when
//  s_axis   in   tdata[7:0] payload_byte, tlast last_byte            s_tvalid && s_tready
//  m_axis   out  tdata: channel, level, universe; tuser: data_valid, verdict
//                                                                    m_tvalid && m_tready
//
// A byte is taken each cycle that s_tready is high; any result of it is registered.
// The header fields are captured by a single pass of logic into the state registers.
// An output register plus one skid register keep input and output decoupled; s_tready
// falls only while the skid register holds a result that the sink has not taken.
// Reset clears the byte offset and captured header, and empties both result registers.
module artnet_packet_classifier_top
#(
    parameter int MAX_CHANNELS = apc_pkg::MAX_CHANNELS_DEF,
    parameter int BUFFER_BYTES = apc_pkg::BUFFER_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [apc_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] payload_byte
    input  logic                          s_tlast,  // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [apc_pkg::M_TDATA_W-1:0] m_tdata,  // [8:0] channel, [16:9] level,
                                                    // [32:17] universe, [39:33] zero
    output logic [apc_pkg::M_TUSER_W-1:0] m_tuser   // [0] data_valid, [3:1] verdict
);
    import apc_pkg::*;

`include "artnet_packet_classifier_top_macros.svh"

    localparam logic [OFF_W-1:0] BUF_L   = OFF_W'(BUFFER_BYTES);
    localparam logic [15:0]      MAX_CH16 = 16'(MAX_CHANNELS);

    // Parser state.
    logic [OFF_W-1:0] off_reg, off_next;
    logic             ident_reg, ident_next;
    logic [15:0]      opc_reg, opc_next;
    logic [15:0]      ver_reg, ver_next;
    logic [15:0]      uni_reg, uni_next;
    logic [15:0]      len_reg, len_next;

    // Result registers.
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    // Per-byte values.
    logic             in_ok;
    logic             in_buf;
    logic             cap_ident;
    logic [15:0]      cap_opc, cap_ver, cap_uni, cap_len;
    logic [OFF_W-1:0] count;
    logic [OFF_W-1:0] slot;
    logic             gate;
    logic             dv;
    verdict_t         verdict;
    result_t          res;
    logic             push;
    logic             out_take;

    assign in_ok    = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign out_take = out_valid_reg && m_tready;
    assign in_buf   = off_reg < BUF_L;

    // Header capture for the current byte.
    always_comb
    begin
        cap_ident = ident_reg;
        cap_opc   = opc_reg;
        cap_ver   = ver_reg;
        cap_uni   = uni_reg;
        cap_len   = len_reg;
        if (in_buf)
        begin
            if (off_reg < OFF_IDENT_END)
            begin
                if (s_tdata != ident_byte(off_reg[2:0]))
                begin
                    cap_ident = 1'b0;
                end
            end
            else
            begin
                case (off_reg)
                    OFF_OPC_LO: cap_opc = {opc_reg[15:8], s_tdata};
                    OFF_OPC_HI: cap_opc = {s_tdata, opc_reg[7:0]};
                    OFF_VER_HI: cap_ver = {s_tdata, ver_reg[7:0]};
                    OFF_VER_LO: cap_ver = {ver_reg[15:8], s_tdata};
                    OFF_UNI_LO: cap_uni = {uni_reg[15:8], s_tdata};
                    OFF_UNI_HI: cap_uni = {s_tdata, uni_reg[7:0]};
                    OFF_LEN_HI: cap_len = {s_tdata, len_reg[7:0]};
                    OFF_LEN_LO: cap_len = {len_reg[15:8], s_tdata};
                    default:    ;
                endcase
            end
        end
    end

    // DMX slot gating.
    assign slot = off_reg - DMX_HDR_BYTES;
    assign gate = in_buf && (off_reg >= DMX_HDR_BYTES) && cap_ident &&
                  (cap_opc == OP_DMX) && (cap_ver >= MIN_VERSION);
    assign dv   = gate && ({6'b0, slot} < cap_len) && ({6'b0, slot} < MAX_CH16);

    // Byte count of the packet, capped at the buffer size.
    assign count = in_buf ? off_reg + 10'd1 : BUF_L;

    // Verdict on the final byte.
    always_comb
    begin
        if (!s_tlast)
        begin
            verdict = VERDICT_NONE;
        end
        else if (count < HDR_BYTES || !cap_ident || cap_ver < MIN_VERSION)
        begin
            verdict = VERDICT_IGNORED;
        end
        else if (cap_opc == OP_POLL)
        begin
            verdict = VERDICT_POLL;
        end
        else if (cap_opc != OP_DMX)
        begin
            verdict = VERDICT_IGNORED;
        end
        else if (count < DMX_HDR_BYTES || cap_len > MAX_CH16 ||
                 {7'b0, count} < ({1'b0, cap_len} + 17'(DMX_HDR_BYTES)))
        begin
            verdict = VERDICT_MALFORMED;
        end
        else
        begin
            verdict = VERDICT_ACCEPT;
        end
    end

    // Result of the current byte.
    always_comb
    begin
        res.data_valid = dv;
        res.channel    = dv ? slot[8:0] : 9'd0;
        res.level      = dv ? s_tdata : 8'd0;
        res.verdict    = verdict;
        res.universe   = s_tlast ? cap_uni : 16'd0;
    end

    assign push = in_ok && (dv || s_tlast);

    // Next parser state: capture on each byte, clear after the final byte.
    always_comb
    begin
        off_next   = off_reg;
        ident_next = ident_reg;
        opc_next   = opc_reg;
        ver_next   = ver_reg;
        uni_next   = uni_reg;
        len_next   = len_reg;
        if (in_ok)
        begin
            if (s_tlast)
            begin
                off_next   = '0;
                ident_next = 1'b1;
                opc_next   = '0;
                ver_next   = '0;
                uni_next   = '0;
                len_next   = '0;
            end
            else
            begin
                off_next   = in_buf ? off_reg + 10'd1 : off_reg;
                ident_next = cap_ident;
                opc_next   = cap_opc;
                ver_next   = cap_ver;
                uni_next   = cap_uni;
                len_next   = cap_len;
            end
        end
    end

    // Output register and skid register steering.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg        <= '0;
            ident_reg      <= 1'b1;
            opc_reg        <= '0;
            ver_reg        <= '0;
            uni_reg        <= '0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            off_reg        <= off_next;
            ident_reg      <= ident_next;
            opc_reg        <= opc_next;
            ver_reg        <= ver_next;
            uni_reg        <= uni_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.universe, out_reg.level, out_reg.channel};
    assign m_tuser  = {out_reg.verdict, out_reg.data_valid};

    // The skid register is only filled while the output register is full.
    `APC_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid register holds a result while the output register is empty")
    // Every result carries a DMX slot or a verdict.
    `APC_ASSERT_IMPL(a_result_nonempty, clk, rst_n, out_valid_reg,
        out_reg.data_valid || out_reg.verdict != VERDICT_NONE,
        "result transaction carries neither a slot nor a verdict")
    // The parser restarts after the final byte of a packet.
    `APC_ASSERT_NEXT(a_restart_after_last, clk, rst_n, in_ok && s_tlast,
        off_reg == '0 && ident_reg,
        "parser did not restart after the final byte")
    // The byte offset never runs past the receive buffer.
    `APC_ASSERT_IMPL(a_offset_bound, clk, rst_n, 1'b1, off_reg <= BUF_L,
        "byte offset beyond the receive buffer")

endmodule

@@ tb/artnet_packet_classifier_top_tb.sv @@
// Testbench for the Art-Net packet classifier with directed and random payloads.
`timescale 1ns / 1ps

module artnet_packet_classifier_top_tb;

    import apc_pkg::*;

    // "Art-Net" followed by a zero byte, first byte in the top bits.
    localparam logic [63:0] ART_ID = 64'h4172_742D_4E65_7400;

    // Minimum number of random payload bytes to send after the directed packets.
    localparam int RANDOM_BYTES = 100;

    // One payload byte as it travels on the input stream.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Bytes waiting to be sent, and results the parser model has predicted.
    rx_byte_t   rx_bytes[$];
    result_t    dmx_outputs[$];
    logic [7:0] frame[$];

    int mismatch_count = 0;
    int cyc = 0;
    int stall_left = 0;

    // Parser model state, at its reset values.
    logic [OFF_W-1:0] rx_offset = '0;
    logic             ident_ok = 1'b1;
    logic [15:0]      opcode_seen = '0;
    logic [15:0]      version_seen = '0;
    logic [15:0]      universe_seen = '0;
    logic [15:0]      dmx_length = '0;

    artnet_packet_classifier_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Verdict for a packet of the given byte count, from the captured header.
    function automatic verdict_t judge_packet(input int count);
        if (count < HDR_BYTES)
            return VERDICT_IGNORED;
        if (!ident_ok || version_seen < MIN_VERSION)
            return VERDICT_IGNORED;
        if (opcode_seen == OP_POLL)
            return VERDICT_POLL;
        if (opcode_seen != OP_DMX)
            return VERDICT_IGNORED;
        if (count < DMX_HDR_BYTES)
            return VERDICT_MALFORMED;
        if (dmx_length > MAX_CHANNELS_DEF)
            return VERDICT_MALFORMED;
        if (count < int'(DMX_HDR_BYTES) + int'(dmx_length))
            return VERDICT_MALFORMED;
        return VERDICT_ACCEPT;
    endfunction

    // Advances the parser model by one accepted byte and returns its result, if any.
    function automatic void parse_byte(input logic [7:0] b, input logic last,
                                       output logic emit, output result_t res);
        int off;
        int slot;
        int count;
        off = rx_offset;
        res = '0;
        res.verdict = VERDICT_NONE;
        if (off < BUFFER_BYTES_DEF)
        begin
            // Header capture.
            if (off < 8)
            begin
                if (b != ART_ID[63 - 8 * off -: 8])
                    ident_ok = 1'b0;
            end
            else if (off == OFF_OPC_LO)
                opcode_seen[7:0] = b;
            else if (off == OFF_OPC_HI)
                opcode_seen[15:8] = b;
            else if (off == OFF_VER_HI)
                version_seen[15:8] = b;
            else if (off == OFF_VER_LO)
                version_seen[7:0] = b;
            else if (off == OFF_UNI_LO)
                universe_seen[7:0] = b;
            else if (off == OFF_UNI_HI)
                universe_seen[15:8] = b;
            else if (off == OFF_LEN_HI)
                dmx_length[15:8] = b;
            else if (off == OFF_LEN_LO)
                dmx_length[7:0] = b;

            // Slot data only for a valid ArtDMX header.
            if (off >= DMX_HDR_BYTES && ident_ok && opcode_seen == OP_DMX
                && version_seen >= MIN_VERSION)
            begin
                slot = off - int'(DMX_HDR_BYTES);
                if (slot < dmx_length && slot < MAX_CHANNELS_DEF)
                begin
                    res.data_valid = 1'b1;
                    res.channel = slot[8:0];
                    res.level = b;
                end
            end
            rx_offset = rx_offset + 10'd1;
            count = off + 1;
        end
        else
        begin
            // Bytes past the receive buffer are dropped.
            count = BUFFER_BYTES_DEF;
        end

        if (last)
        begin
            res.verdict = judge_packet(count);
            res.universe = universe_seen;
            rx_offset = '0;
            ident_ok = 1'b1;
            opcode_seen = '0;
            version_seen = '0;
            universe_seen = '0;
            dmx_length = '0;
        end
        emit = res.data_valid || last;
    endfunction

    // Packet assembly helpers working on the scratch frame.
    task automatic start_header(input logic [15:0] opcode, input logic [15:0] version);
        frame.delete();
        for (int i = 0; i < 8; i++)
            frame.push_back(ART_ID[63 - 8 * i -: 8]);
        frame.push_back(opcode[7:0]);
        frame.push_back(opcode[15:8]);
        frame.push_back(version[15:8]);
        frame.push_back(version[7:0]);
    endtask

    task automatic add_dmx_fields(input logic [15:0] universe, input logic [15:0] length);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(universe[7:0]);
        frame.push_back(universe[15:8]);
        frame.push_back(length[15:8]);
        frame.push_back(length[7:0]);
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            frame.push_back(8'($urandom));
    endtask

    task automatic trim_frame(input int n);
        while (frame.size() > n)
            void'(frame.pop_back());
    endtask

    // Moves the scratch frame to the send queue, marking its final byte.
    task automatic flush_frame();
        rx_byte_t item;
        for (int i = 0; i < frame.size(); i++)
        begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            rx_bytes.push_back(item);
        end
        frame.delete();
    endtask

    task automatic queue_dmx(input logic [15:0] version, input logic [15:0] universe,
                             input logic [15:0] length, input int n_data);
        start_header(OP_DMX, version);
        add_dmx_fields(universe, length);
        add_random_bytes(n_data);
        flush_frame();
    endtask

    function automatic logic [15:0] pick_version();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return MIN_VERSION;
        if (r < 20)
            return 16'hFFFF;
        return 16'($urandom_range(int'(MIN_VERSION), 65535));
    endfunction

    // Directed packets: boundaries of length, header and verdict.
    task automatic build_directed();
        // Single byte packet, and a header cut one byte short.
        frame.push_back(8'hFF);
        flush_frame();
        start_header(OP_POLL, MIN_VERSION);
        trim_frame(int'(HDR_BYTES) - 1);
        flush_frame();
        // Bare poll header, then a poll with a version just too old.
        start_header(OP_POLL, MIN_VERSION);
        flush_frame();
        start_header(OP_POLL, MIN_VERSION - 16'd1);
        add_random_bytes(3);
        flush_frame();
        // Identifier with a wrong byte.
        start_header(OP_DMX, MIN_VERSION);
        frame[3] = 8'h2E;
        add_dmx_fields(16'h0001, 16'd2);
        add_random_bytes(2);
        flush_frame();
        // Opcode that is neither poll nor DMX.
        start_header(OP_DMX + 16'd1, 16'hFFFF);
        add_dmx_fields(16'h1234, 16'd2);
        add_random_bytes(2);
        flush_frame();
        // ArtDMX that ends inside its header: first with only half a universe, then one byte short.
        start_header(OP_DMX, MIN_VERSION);
        add_dmx_fields(16'hA55A, 16'd4);
        trim_frame(int'(OFF_UNI_HI));
        flush_frame();
        start_header(OP_DMX, MIN_VERSION);
        add_dmx_fields(16'hA55A, 16'd4);
        trim_frame(int'(DMX_HDR_BYTES) - 1);
        flush_frame();
        // Zero length, exact length, short data and surplus data.
        queue_dmx(16'hFFFF, 16'h0000, 16'd0, 0);
        queue_dmx(MIN_VERSION, 16'hFFFF, 16'd4, 4);
        queue_dmx(MIN_VERSION, 16'h00FF, 16'd4, 2);
        queue_dmx(MIN_VERSION, 16'hFF00, 16'd3, 6);
        // Declared length just over the channel limit, and the largest value.
        queue_dmx(MIN_VERSION, 16'h0102, 16'(MAX_CHANNELS_DEF + 1), 8);
        queue_dmx(MIN_VERSION, 16'h0304, 16'hFFFF, 30);
        // Full universe, then bytes beyond the receive buffer.
        queue_dmx(MIN_VERSION, 16'h8001, 16'(MAX_CHANNELS_DEF), MAX_CHANNELS_DEF + 20);
    endtask

    // Random packets, mostly ArtDMX with random content.
    task automatic build_random();
        int sent;
        int n0;
        int sel;
        int r;
        int len;
        int n_data;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            n0 = rx_bytes.size();
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = $urandom_range(0, 24);
                else if (r < 90)
                    len = $urandom_range(MAX_CHANNELS_DEF + 1, 65535);
                else if (r < 97)
                    len = $urandom_range(25, 100);
                else
                    len = $urandom_range(101, MAX_CHANNELS_DEF);
                r = $urandom_range(0, 99);
                if (len > MAX_CHANNELS_DEF)
                    n_data = $urandom_range(0, 30);
                else if (r < 70 || len == 0)
                    n_data = len;
                else if (r < 85)
                    n_data = $urandom_range(0, len - 1);
                else
                    n_data = len + $urandom_range(1, 5);
                start_header(OP_DMX, pick_version());
                add_dmx_fields(16'($urandom), 16'(len));
                add_random_bytes(n_data);
                if ($urandom_range(0, 99) < 10)
                    trim_frame($urandom_range(1, int'(DMX_HDR_BYTES) - 1));
            end
            else if (sel < 70)
            begin
                start_header(OP_POLL, pick_version());
                add_random_bytes($urandom_range(0, 6));
            end
            else if (sel < 80)
            begin
                // Broken identifier or too old a version.
                if ($urandom_range(0, 1) == 0)
                begin
                    start_header($urandom_range(0, 1) ? OP_DMX : OP_POLL, pick_version());
                    r = $urandom_range(0, 7);
                    frame[r] = frame[r] ^ (8'd1 << $urandom_range(0, 7));
                end
                else
                begin
                    start_header($urandom_range(0, 1) ? OP_DMX : OP_POLL,
                                 16'($urandom_range(0, int'(MIN_VERSION) - 1)));
                end
                add_dmx_fields(16'($urandom), 16'($urandom_range(0, 8)));
                add_random_bytes($urandom_range(0, 8));
            end
            else if (sel < 90)
            begin
                start_header(16'($urandom), pick_version());
                add_random_bytes($urandom_range(0, 10));
            end
            else
            begin
                add_random_bytes($urandom_range(1, 20));
            end
            flush_frame();
            sent += rx_bytes.size() - n0;
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Cycle counter and the long hold-off of the sink.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            if (cyc == 400)
                stall_left <= 300;
            else if (stall_left > 0)
                stall_left <= stall_left - 1;
        end
    end

    // Source: offers queued bytes and feeds accepted ones to the parser model.
    always @(posedge clk)
    begin : source
        logic     emit;
        result_t  res;
        logic     steady;
        steady = (cyc >= 750 && cyc < 1150);
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast, emit, res);
                if (emit)
                    dmx_outputs.push_back(res);
                void'(rx_bytes.pop_front());
            end
            if (s_tvalid && !s_tready)
            begin
                // Hold the offered transaction until it is taken.
            end
            else if (rx_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= 25))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_bytes[0].data;
                s_tlast <= rx_bytes[0].last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: checks each result transaction against the oldest prediction.
    always @(posedge clk)
    begin : sink
        result_t seen;
        result_t want;
        logic    steady;
        steady = (cyc >= 750 && cyc < 1150);
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.data_valid = m_tuser[0];
                seen.verdict = verdict_t'(m_tuser[3:1]);
                seen.channel = m_tdata[8:0];
                seen.level = m_tdata[16:9];
                seen.universe = m_tdata[32:17];
                if (dmx_outputs.size() == 0)
                begin
                    flag_mismatch("result transaction with none expected");
                end
                else
                begin
                    want = dmx_outputs.pop_front();
                    if (seen.data_valid !== want.data_valid)
                        flag_mismatch($sformatf("data_valid got %0d expected %0d",
                                                seen.data_valid, want.data_valid));
                    if (seen.channel !== want.channel)
                        flag_mismatch($sformatf("channel got %0d expected %0d",
                                                seen.channel, want.channel));
                    if (seen.level !== want.level)
                        flag_mismatch($sformatf("level got %0h expected %0h",
                                                seen.level, want.level));
                    if (seen.verdict !== want.verdict)
                        flag_mismatch($sformatf("verdict got %0d expected %0d",
                                                seen.verdict, want.verdict));
                    if (seen.universe !== want.universe)
                        flag_mismatch($sformatf("universe got %0h expected %0h",
                                                seen.universe, want.universe));
                end
            end
            m_tready <= (stall_left == 0) && (steady || $urandom_range(0, 99) >= 25);
        end
    end

    // Stimulus, reset and end of the run.
    initial
    begin
        build_directed();
        build_random();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (rx_bytes.size() != 0 || dmx_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && dmx_outputs.size() == 0)
            $display("PASS artnet_packet_classifier_top");
        else
            $display("FAIL artnet_packet_classifier_top");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #400000;
        $display("FAIL artnet_packet_classifier_top");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/apc_pkg.sv
rtl/artnet_packet_classifier_top.sv
tb/artnet_packet_classifier_top_tb.sv
